[hdl/flash_word_write_aligner_macros.svh]
// ----------------------------------------------------------------------------
// flash word write aligner assertion macros
// shared property forms for the aligner's concurrent checks
// ----------------------------------------------------------------------------
`ifndef FLASH_WORD_WRITE_ALIGNER_MACROS_SVH
`define FLASH_WORD_WRITE_ALIGNER_MACROS_SVH

// same-cycle implication, checked outside reset
`define FWWA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("aligner check failed");

// next-cycle implication, checked outside reset
`define FWWA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("aligner check failed");

`endif

[hdl/fwwa_pkg.sv]
// ----------------------------------------------------------------------------
// fwwa_pkg
// types and constants shared by the flash word write aligner
// ----------------------------------------------------------------------------
package fwwa_pkg;

	// fixed field widths
	localparam int unsigned ADDR_W       = 32;
	localparam int unsigned WORD_W       = 32;
	localparam int unsigned BYTE_COUNT_W = 21;
	localparam int unsigned CFG_W        = 32;

	// erased flash word, also the tail pad
	localparam logic [WORD_W-1:0] ERASED_WORD = 32'hFFFF_FFFF;

	// register reset values
	localparam logic [CFG_W-1:0] WINDOW_START_RESET = 32'h0800_0000;
	localparam logic [CFG_W-1:0] WINDOW_END_RESET   = 32'h0807_FFFF;

	// request status codes
	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_REJECTED = 1'b1;

	// register indexes
	typedef enum logic [0:0] {
		CFG_WINDOW_START = 1'b0,
		CFG_WINDOW_END   = 1'b1
	} cfg_index_t;

	// one input item
	typedef struct packed {
		logic                    first_item;
		logic [ADDR_W-1:0]       dest_address;
		logic [BYTE_COUNT_W-1:0] byte_count;
		logic [WORD_W-1:0]       head_existing;
		logic [7:0]              data_byte;
	} item_t;

	// one result item
	typedef struct packed {
		logic              word_valid;
		logic [ADDR_W-1:0] word_address;
		logic [WORD_W-1:0] word_value;
		logic              request_done;
		logic              status;
	} result_t;

	// address window handed to the packer
	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] last;
	} window_t;

endpackage

[hdl/fwwa_packer.sv]
// ----------------------------------------------------------------------------
// fwwa_packer
// request state and byte-to-word packing, one item per step
// ----------------------------------------------------------------------------
module fwwa_packer
	import fwwa_pkg::*;
#(
	parameter int unsigned LenBits = 21
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	input  window_t window,
	output result_t result
);

	localparam int unsigned SumW = ADDR_W + 2;

	logic [WORD_W-1:0]  pack_word_q;
	logic [ADDR_W-1:0]  next_address_q;
	logic [LenBits-1:0] bytes_left_q;
	logic               dropping_q;

	logic [WORD_W-1:0]  pack_word_n;
	logic [ADDR_W-1:0]  next_address_n;
	logic [LenBits-1:0] bytes_left_n;
	logic               dropping_n;

	logic [LenBits-1:0] count;
	logic [LenBits-1:0] bl_base;
	logic [LenBits-1:0] bl_dec;
	logic [SumW-1:0]    last_addr;
	logic               reject;
	logic [ADDR_W-1:0]  addr;
	logic [WORD_W-1:0]  base_word;
	logic [WORD_W-1:0]  packed_word;
	logic               emit;

	// length as seen by the request logic
	if (LenBits <= BYTE_COUNT_W) begin : g_count_trunc
		assign count = item.byte_count[LenBits-1:0];
	end else begin : g_count_ext
		assign count = {{(LenBits-BYTE_COUNT_W){1'b0}}, item.byte_count};
	end

	// span check without wrap
	assign last_addr = {2'b00, item.dest_address}
		+ {{(SumW-LenBits){1'b0}}, count} - {{(SumW-1){1'b0}}, 1'b1};
	assign reject = (item.dest_address < window.start)
		|| (last_addr > {2'b00, window.last});

	// byte placement for a new or continuing request
	always_comb begin
		addr      = item.first_item ? item.dest_address : next_address_q;
		bl_base   = item.first_item ? count : bytes_left_q;
		bl_dec    = bl_base - {{(LenBits-1){1'b0}}, 1'b1};
		base_word = pack_word_q;
		if (item.first_item) begin
			base_word = (item.dest_address[1:0] != 2'b00) ? item.head_existing : ERASED_WORD;
		end
		packed_word = base_word;
		unique case (addr[1:0])
			2'd0: packed_word[7:0]   = item.data_byte;
			2'd1: packed_word[15:8]  = item.data_byte;
			2'd2: packed_word[23:16] = item.data_byte;
			2'd3: packed_word[31:24] = item.data_byte;
			default: packed_word = base_word;
		endcase
		emit = (addr[1:0] == 2'b11) || (bl_dec == '0);
	end

	// next state and result
	always_comb begin
		pack_word_n    = pack_word_q;
		next_address_n = next_address_q;
		bytes_left_n   = bytes_left_q;
		dropping_n     = dropping_q;
		result         = '0;
		priority if (item.first_item && (count == '0)) begin
			pack_word_n         = ERASED_WORD;
			bytes_left_n        = '0;
			dropping_n          = 1'b0;
			result.request_done = 1'b1;
		end else if (item.first_item && reject) begin
			pack_word_n         = ERASED_WORD;
			bytes_left_n        = bl_dec;
			dropping_n          = (bl_dec != '0);
			result.request_done = 1'b1;
			result.status       = STATUS_REJECTED;
		end else if (!item.first_item && (bytes_left_q == '0)) begin
			dropping_n = 1'b0;
		end else if (!item.first_item && dropping_q) begin
			bytes_left_n = bl_dec;
			dropping_n   = (bl_dec != '0);
		end else begin
			// take one byte, issue the word when full or at the end
			dropping_n     = 1'b0;
			bytes_left_n   = bl_dec;
			next_address_n = addr + 32'd1;
			pack_word_n    = emit ? ERASED_WORD : packed_word;
			if (emit) begin
				result.word_valid   = 1'b1;
				result.word_address = {addr[ADDR_W-1:2], 2'b00};
				result.word_value   = packed_word;
			end
			result.request_done = (bl_dec == '0);
		end
	end

	// request state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_word_q    <= ERASED_WORD;
			next_address_q <= '0;
			bytes_left_q   <= '0;
			dropping_q     <= 1'b0;
		end else if (step) begin
			pack_word_q    <= pack_word_n;
			next_address_q <= next_address_n;
			bytes_left_q   <= bytes_left_n;
			dropping_q     <= dropping_n;
		end
	end

endmodule

[hdl/flash_word_write_aligner.sv]
// ----------------------------------------------------------------------------
// flash_word_write_aligner
// packs a byte-stream write request into aligned 32-bit program words
// ----------------------------------------------------------------------------
// Usage: the item channel (item_valid, item_stall, item) carries one byte of a
// write request per item; the first item of a request also carries the
// destination, the length and the current flash word at the aligned head.
// The result channel (result_valid, result_stall, result) returns exactly one
// result per item: a program word when a lane 3 byte or the last byte lands,
// and request_done/status on the item that ends a request.
// An item passes the input stage, then the result register. Throughput is one
// item per cycle while result_stall is low; the packing logic between them is a
// lane insert, a decrement and the window compare. The user must write the
// window registers via cfg_we/cfg_index/cfg_data only while the block is idle;
// the block does not enforce it. Reset restores the default window, clears the
// request state and empties both stages. While result_stall is high the result
// holds and the input stage can still take one item, then item_stall rises.
// ----------------------------------------------------------------------------
`include "flash_word_write_aligner_macros.svh"

module flash_word_write_aligner
	import fwwa_pkg::*;
#(
	parameter int unsigned MAX_LENGTH_BITS = 21
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  item_t            item,
	output logic             result_valid,
	input  logic             result_stall,
	output result_t          result,
	input  logic             cfg_we,
	input  cfg_index_t       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic    stage_valid_s1;
	item_t   item_s1;
	logic    result_valid_q;
	result_t result_q;
	window_t window_q;
	result_t step_result;
	logic    advance;
	logic    accept;
	logic    step;

	// handshake
	assign advance    = !result_valid_q || !result_stall;
	assign item_stall = stage_valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;
	assign step       = stage_valid_s1 && advance;

	// window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q.start <= WINDOW_START_RESET;
			window_q.last  <= WINDOW_END_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WINDOW_START: window_q.start <= cfg_data;
				CFG_WINDOW_END:   window_q.last  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_s1 <= 1'b0;
		end else if (accept) begin
			stage_valid_s1 <= 1'b1;
		end else if (step) begin
			stage_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// packing and request state
	fwwa_packer #(
		.LenBits(MAX_LENGTH_BITS)
	) u_packer (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step),
		.item  (item_s1),
		.window(window_q),
		.result(step_result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= stage_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= step_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// checks
	`FWWA_ASSERT_IMPL(a_stall_needs_stage, clk, arst_n, item_stall, stage_valid_s1 && result_valid_q)
	`FWWA_ASSERT_IMPL(a_status_with_done, clk, arst_n, result_valid && result.status, result.request_done)
	`FWWA_ASSERT_IMPL(a_word_aligned, clk, arst_n, result_valid && result.word_valid, result.word_address[1:0] == 2'b00)
	`FWWA_ASSERT_IMPL(a_no_word_zero, clk, arst_n, result_valid && !result.word_valid, (result.word_address == '0) && (result.word_value == '0))
	`FWWA_ASSERT_NEXT(a_step_gives_result, clk, arst_n, step, result_valid)

endmodule
